>>> hw/rtl/prmet_pkg.sv
// Shared types and constants for the pair-region minimum energy table.
// Holds the request/response transaction structs, status codes and index helpers.
// No dependencies.
`default_nettype none

package prmet_pkg;

  localparam int IDX_W = 9;
  localparam int ENERGY_W = 16;
  localparam logic [IDX_W-1:0] LAST_POS = 9'd256;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [1:0] CFG_SEQ1_LEN = 2'd0;
  localparam logic [1:0] CFG_SEQ2_LEN = 2'd1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_ORDER = 2'd2
  } status_t;

  typedef struct packed {
    logic                       req_type;
    logic [IDX_W-1:0]           start1;
    logic [IDX_W-1:0]           end1;
    logic [IDX_W-1:0]           start2;
    logic [IDX_W-1:0]           end2;
    logic signed [ENERGY_W-1:0] energy;
  } req_item_t;

  typedef struct packed {
    logic signed [ENERGY_W-1:0] min_energy;
    logic                       is_infinite;
    status_t                    status;
  } rsp_item_t;

  // Length register write: zero holds as one, oversize holds as the cap.
  function automatic logic [IDX_W-1:0] clamp_len(input logic [IDX_W-1:0] v,
                                                 input logic [IDX_W-1:0] cap);
    logic [IDX_W-1:0] r;
    if (v == '0) r = IDX_W'(1);
    else if (v > cap) r = cap;
    else r = v;
    return r;
  endfunction

  // The last-position code stands for len - 1.
  function automatic logic [IDX_W-1:0] map_idx(input logic [IDX_W-1:0] x,
                                               input logic [IDX_W-1:0] len);
    logic [IDX_W-1:0] r;
    if (x == LAST_POS) r = len - IDX_W'(1);
    else r = x;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pair_region_min_energy_table_top.sv
// Pair-region minimum energy table: top level with sequencer, compare unit and table memory.
// Depends on prmet_pkg.
//
// Keeps a running minimum energy per position pair in one memory with a
// registered read port and a write port. After reset the block sweeps the
// whole table of 2**(ROW_W+COL_W) entries (65536 at the default sizes) to
// "infinite", one entry per cycle; no request is taken during that sweep,
// but configuration writes are. An update request walks its rectangle one
// entry per cycle through a single compare unit (read one entry while the
// previous one is compared and written back) and takes no new request
// until it is done. A read passes through S_READ to S_RESULT, a rejected
// request goes straight to S_RESULT. The memory's single read port sets
// the one-entry-per-cycle walk rate. A response may wait on rsp_stall
// while the next request is already accepted.
`default_nettype none

module pair_region_min_energy_table_top
  import prmet_pkg::*;
#(
  parameter int MAX_LEN1 = 256,
  parameter int MAX_LEN2 = 256
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              cfg_we,
  input  wire [1:0]        cfg_index,
  input  wire [IDX_W-1:0]  cfg_data,
  input  wire              req_valid,
  output logic             req_stall,
  input  req_item_t        req_data,
  output logic             rsp_valid,
  input  wire              rsp_stall,
  output rsp_item_t        rsp_data
);

  localparam int ROW_W = $clog2(MAX_LEN1);
  localparam int COL_W = $clog2(MAX_LEN2);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH = 1 << ADDR_W;
  localparam int LEN_MAX1 = (MAX_LEN1 > 511) ? 511 : MAX_LEN1;
  localparam int LEN_MAX2 = (MAX_LEN2 > 511) ? 511 : MAX_LEN2;
  localparam logic [IDX_W-1:0] LEN_CAP1 = IDX_W'(LEN_MAX1);
  localparam logic [IDX_W-1:0] LEN_CAP2 = IDX_W'(LEN_MAX2);
  localparam logic [ENERGY_W:0] ENTRY_INF = {1'b1, {ENERGY_W{1'b0}}};

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_READ,
    S_RESULT
  } state_t;

  state_t state;

  logic [IDX_W-1:0] len1;
  logic [IDX_W-1:0] len2;

  logic [ADDR_W-1:0] clr_cnt;
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  row_hi;
  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  col_lo;
  logic [COL_W-1:0]  col_hi;
  logic signed [ENERGY_W-1:0] energy_q;
  logic              is_read;
  status_t           stat_q;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;

  // table entry: [ENERGY_W] = infinite flag, low bits = value
  logic [ENERGY_W:0] mem [DEPTH];
  logic [ENERGY_W:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [ENERGY_W:0] wr_data;

  logic [IDX_W-1:0] a1, b1, a2, b2;
  status_t          chk_stat;
  logic             better;

  assign req_stall = (state != S_IDLE);
  assign rd_addr = {row, col};

  always_comb begin
    a1 = map_idx(req_data.start1, len1);
    b1 = map_idx(req_data.end1, len1);
    a2 = map_idx(req_data.start2, len2);
    b2 = map_idx(req_data.end2, len2);
    if (req_data.req_type == REQ_READ) begin
      if (a1 >= len1 || a2 >= len2) chk_stat = STAT_RANGE;
      else chk_stat = STAT_OK;
    end else begin
      if (a1 >= len1 || b1 >= len1) chk_stat = STAT_RANGE;
      else if (a1 > b1) chk_stat = STAT_ORDER;
      else if (a2 >= len2 || b2 >= len2) chk_stat = STAT_RANGE;
      else if (a2 > b2) chk_stat = STAT_ORDER;
      else chk_stat = STAT_OK;
    end
  end

  // single compare unit: entry read last cycle against the request energy
  assign better = rd_data[ENERGY_W] || (energy_q < $signed(rd_data[ENERGY_W-1:0]));

  always_comb begin
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      wr_addr = clr_cnt;
      wr_data = ENTRY_INF;
    end else begin
      mem_we = pend && better;
      wr_addr = pend_addr;
      wr_data = {1'b0, energy_q};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      pend <= 1'b0;
      rsp_valid <= 1'b0;
      len1 <= clamp_len(LAST_POS, LEN_CAP1);
      len2 <= clamp_len(LAST_POS, LEN_CAP2);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEQ1_LEN: len1 <= clamp_len(cfg_data, LEN_CAP1);
          CFG_SEQ2_LEN: len2 <= clamp_len(cfg_data, LEN_CAP2);
          default: ;
        endcase
      end

      if (state == S_RESULT && (!rsp_valid || !rsp_stall)) rsp_valid <= 1'b1;
      else if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      pend <= (state == S_WALK);

      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) begin
            is_read <= (req_data.req_type == REQ_READ);
            stat_q <= chk_stat;
            energy_q <= req_data.energy;
            row <= ROW_W'(a1);
            col <= COL_W'(a2);
            col_lo <= COL_W'(a2);
            row_hi <= ROW_W'(b1);
            col_hi <= COL_W'(b2);
            if (chk_stat != STAT_OK) state <= S_RESULT;
            else if (req_data.req_type == REQ_READ) state <= S_READ;
            else state <= S_WALK;
          end
        end
        S_WALK: begin
          pend_addr <= rd_addr;
          if (col == col_hi) begin
            if (row == row_hi) begin
              state <= S_DRAIN;
            end else begin
              row <= row + ROW_W'(1);
              col <= col_lo;
            end
          end else begin
            col <= col + COL_W'(1);
          end
        end
        S_DRAIN: begin
          // last entry compared and written this cycle
          state <= S_RESULT;
        end
        S_READ: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_data.status <= stat_q;
            if (is_read && stat_q == STAT_OK) begin
              rsp_data.is_infinite <= rd_data[ENERGY_W];
              rsp_data.min_energy <= rd_data[ENERGY_W] ? '0 : rd_data[ENERGY_W-1:0];
            end else begin
              rsp_data.is_infinite <= 1'b0;
              rsp_data.min_energy <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_RESULT) |-> !mem_we)
    else $error("table written outside clear or walk");

  a_walk_in_rect: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (row <= row_hi && col <= col_hi && col >= col_lo))
    else $error("walk left its rectangle");

  a_write_pending: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state != S_CLEAR) |-> pend)
    else $error("update write without a pending compare");

  a_read_to_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_DRAIN) |=> (state == S_RESULT))
    else $error("read or drain not followed by result");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.status != STAT_OK) |->
      (rsp_data.min_energy == '0 && !rsp_data.is_infinite))
    else $error("rejected request returned entry data");

endmodule

`default_nettype wire
